@@ hw/rtl/lfu_pkg.sv @@
// Shared types and constants for the LFU slot table.
`timescale 1ns / 1ps

package lfu_pkg;

   localparam int ID_IN_W    = 7;
   localparam int STAMP_W    = 16;
   localparam int SLOT_OUT_W = 5;
   localparam int EVICT_W    = 7;
   localparam int COUNT_W    = 16;
   localparam int CFG_W      = 6;

   localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
   localparam logic [COUNT_W-1:0] COUNT_FIRST = COUNT_W'(1);
   localparam logic [CFG_W-1:0]   CFG_RESET   = CFG_W'(32);

   typedef enum logic [1:0] {
      ACT_HIT     = 2'd0,
      ACT_FILL    = 2'd1,
      ACT_REPLACE = 2'd2
   } lfu_action_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_HIT,
      ST_SCAN,
      ST_EVICT,
      ST_WRITE
   } lfu_state_type;

   typedef struct packed {
      logic load;
      logic first;
   } lfu_scan_ctrl_type;

endpackage

@@ hw/rtl/lfu_if.sv @@
// Request, response and register-write channel interfaces.
`timescale 1ns / 1ps

interface lfu_req_if import lfu_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ID_IN_W-1:0]   candidate_id;
   logic [STAMP_W-1:0]   stamp;

   modport source (output valid, output candidate_id, output stamp, input ready);
   modport sink   (input valid, input candidate_id, input stamp, output ready);
endinterface

interface lfu_rsp_if import lfu_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [SLOT_OUT_W-1:0] slot;
   lfu_action_type        action;
   logic [EVICT_W-1:0]    evicted_id;
   logic [COUNT_W-1:0]    new_count;

   modport source (output valid, output slot, output action, output evicted_id,
                   output new_count, input ready);
   modport sink   (input valid, input slot, input action, input evicted_id,
                   input new_count, output ready);
endinterface

interface lfu_csr_if import lfu_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CFG_W-1:0]  active_slots;

   modport source (output valid, output active_slots, input ready);
   modport sink   (input valid, input active_slots, output ready);
endinterface

@@ hw/rtl/lfu_id_reduce.sv @@
// Reduces a raw request id modulo the id space by restoring subtract steps.
`timescale 1ns / 1ps

module lfu_id_reduce import lfu_pkg::*; #(
   parameter int ID_COUNT = 128,
   parameter int ID_W     = 7
) (
   input  logic [ID_IN_W-1:0] raw_id,
   output logic [ID_W-1:0]    id
);

   always_comb begin
      logic [ID_IN_W-1:0] rem;
      rem = raw_id;
      // subtract shifted multiples of the id space, largest first
      for (int k = ID_IN_W - 1; k >= 0; k--) begin
         if ((ID_COUNT << k) < (1 << ID_IN_W)) begin
            if (rem >= ID_IN_W'(ID_COUNT << k)) begin
               rem = rem - ID_IN_W'(ID_COUNT << k);
            end
         end
      end
      id = ID_W'(rem);
   end

endmodule

@@ hw/rtl/lfu_scan.sv @@
// Shared compare unit and best-so-far registers for the victim search.
`timescale 1ns / 1ps

module lfu_scan import lfu_pkg::*; #(
   parameter int SLOT_W = 5,
   parameter int ID_W   = 7
) (
   input  logic                clock,
   input  lfu_scan_ctrl_type   ctrl,
   input  logic [SLOT_W-1:0]   idx,
   input  logic [ID_W-1:0]     owner,
   input  logic [COUNT_W-1:0]  count,
   input  logic [STAMP_W-1:0]  stamp,
   output logic [SLOT_W-1:0]   best_slot,
   output logic [ID_W-1:0]     best_owner
);

   logic [COUNT_W-1:0] best_count_ff;
   logic [STAMP_W-1:0] best_stamp_ff;
   logic [SLOT_W-1:0]  best_slot_ff;
   logic [ID_W-1:0]    best_owner_ff;
   logic               better;

   // strict compares keep the lower index on a full tie
   assign better = ctrl.first || (count < best_count_ff) ||
                   ((count == best_count_ff) && (stamp < best_stamp_ff));

   always_ff @(posedge clock) begin
      if (ctrl.load && better) begin
         best_count_ff <= count;
         best_stamp_ff <= stamp;
         best_slot_ff  <= idx;
         best_owner_ff <= owner;
      end
   end

   assign best_slot  = best_slot_ff;
   assign best_owner = best_owner_ff;

endmodule

@@ hw/rtl/lfu_slot_table_replacement.sv @@
// Each request passes through LOOKUP, then HIT and WRITE on a hit, WRITE alone on a fill, or
// SCAN over the filled slots, EVICT and WRITE on a replace. One request is handled at a time;
// it is held in WRITE while a result waits. The next is taken once the result is registered.
// The replace path walks the slot table memory one entry per cycle through one compare unit.
// Reset: synchronous; after it every id map entry is swept clear in turn,
// during which no request is taken (register writes are accepted throughout).
`timescale 1ns / 1ps

module lfu_slot_table_replacement import lfu_pkg::*; #(
   parameter int MAX_SLOTS = 32,
   parameter int ID_COUNT  = 128
) (
   input  logic      clock,
   input  logic      reset,
   lfu_req_if.sink   req_if,
   lfu_rsp_if.source rsp_if,
   lfu_csr_if.sink   csr_if
);

   localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int USED_W = $clog2(MAX_SLOTS + 1);
   localparam int ID_W   = $clog2(ID_COUNT);
   localparam int MAP_W  = SLOT_W + 1;
   localparam int CMP_W  = (USED_W > CFG_W) ? USED_W : CFG_W;

   typedef struct packed {
      logic [ID_W-1:0]    owner;
      logic [COUNT_W-1:0] count;
      logic [STAMP_W-1:0] stamp;
   } slot_entry_type;

   // memories
   logic [MAP_W-1:0] map_mem [ID_COUNT];
   slot_entry_type   slot_mem [MAX_SLOTS];
   logic [MAP_W-1:0] map_rd_ff;
   slot_entry_type   slot_rd_ff;

   // control state
   lfu_state_type    state_ff, state_in;
   logic [CFG_W-1:0] active_ff;
   logic [USED_W-1:0] used_ff, used_in;
   logic [ID_W-1:0]  clr_idx_ff, clr_idx_in;
   logic [SLOT_W-1:0] scan_idx_ff, scan_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // per-request payload
   logic [ID_W-1:0]    id_ff, id_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   lfu_action_type     action_ff, action_in;
   logic [ID_W-1:0]    evict_ff, evict_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic [SLOT_OUT_W-1:0] rsp_slot_ff;
   lfu_action_type        rsp_action_ff;
   logic [EVICT_W-1:0]    rsp_evict_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;

   // control wires
   logic              req_accept;
   logic              out_free;
   logic              map_hit;
   logic [SLOT_W-1:0] map_slot;
   logic [CMP_W-1:0]  eff_slots;
   logic              has_free;
   logic              scan_last;
   logic              clr_last;
   logic [ID_W-1:0]   req_id;
   logic              map_we;
   logic [ID_W-1:0]   map_waddr;
   logic [MAP_W-1:0]  map_wdata;
   logic              slot_we;
   logic [SLOT_W-1:0] slot_raddr;
   lfu_scan_ctrl_type scan_ctrl;
   logic [SLOT_W-1:0] best_slot;
   logic [ID_W-1:0]   best_owner;
   logic [COUNT_W-1:0] hit_count;

   lfu_id_reduce #(
      .ID_COUNT (ID_COUNT),
      .ID_W     (ID_W)
   ) u_id_reduce (
      .raw_id (req_if.candidate_id),
      .id     (req_id)
   );

   lfu_scan #(
      .SLOT_W (SLOT_W),
      .ID_W   (ID_W)
   ) u_scan (
      .clock      (clock),
      .ctrl       (scan_ctrl),
      .idx        (scan_idx_ff),
      .owner      (slot_rd_ff.owner),
      .count      (slot_rd_ff.count),
      .stamp      (slot_rd_ff.stamp),
      .best_slot  (best_slot),
      .best_owner (best_owner)
   );

   assign req_if.ready = (state_ff == ST_IDLE);
   assign csr_if.ready = 1'b1;
   assign req_accept   = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   assign map_hit  = map_rd_ff[SLOT_W];
   assign map_slot = map_rd_ff[SLOT_W-1:0];

   always_comb begin
      if (active_ff == '0) begin
         eff_slots = CMP_W'(1);
      end else if (CMP_W'(active_ff) > CMP_W'(MAX_SLOTS)) begin
         eff_slots = CMP_W'(MAX_SLOTS);
      end else begin
         eff_slots = CMP_W'(active_ff);
      end
   end

   assign has_free  = CMP_W'(used_ff) < eff_slots;
   assign scan_last = USED_W'(scan_idx_ff) == USED_W'(used_ff - USED_W'(1));
   assign clr_last  = clr_idx_ff == ID_W'(ID_COUNT - 1);
   assign hit_count = (slot_rd_ff.count == COUNT_MAX) ? slot_rd_ff.count
                                                      : slot_rd_ff.count + COUNT_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (clr_last) state_in = ST_IDLE;
         ST_IDLE:   if (req_accept) state_in = ST_LOOKUP;
         ST_LOOKUP: begin
            if (map_hit) begin
               state_in = ST_HIT;
            end else if (has_free) begin
               state_in = ST_WRITE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_HIT:    state_in = ST_WRITE;
         ST_SCAN:   if (scan_last) state_in = ST_EVICT;
         ST_EVICT:  state_in = ST_WRITE;
         ST_WRITE:  if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      clr_idx_in   = clr_idx_ff;
      scan_idx_in  = scan_idx_ff;
      used_in      = used_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      id_in        = id_ff;
      stamp_in     = stamp_ff;
      slot_in      = slot_ff;
      action_in    = action_ff;
      evict_in     = evict_ff;
      count_in     = count_ff;
      map_we       = 1'b0;
      map_waddr    = id_ff;
      map_wdata    = {1'b1, slot_ff};
      slot_we      = 1'b0;
      slot_raddr   = '0;
      scan_ctrl    = '{load: 1'b0, first: 1'b0};
      unique case (state_ff)
         ST_CLEAR: begin
            map_we     = 1'b1;
            map_waddr  = clr_idx_ff;
            map_wdata  = '0;
            clr_idx_in = clr_idx_ff + ID_W'(1);
         end
         ST_IDLE: begin
            id_in    = req_id;
            stamp_in = req_if.stamp;
         end
         ST_LOOKUP: begin
            evict_in    = '0;
            count_in    = COUNT_FIRST;
            scan_idx_in = '0;
            if (map_hit) begin
               action_in  = ACT_HIT;
               slot_in    = map_slot;
               slot_raddr = map_slot;
            end else if (has_free) begin
               action_in = ACT_FILL;
               slot_in   = SLOT_W'(used_ff);
            end else begin
               action_in = ACT_REPLACE;
            end
         end
         ST_HIT: begin
            // keep the slot's insertion stamp, bump the count
            count_in = hit_count;
            stamp_in = slot_rd_ff.stamp;
         end
         ST_SCAN: begin
            scan_ctrl   = '{load: 1'b1, first: (scan_idx_ff == '0)};
            scan_idx_in = scan_idx_ff + SLOT_W'(1);
            slot_raddr  = scan_idx_ff + SLOT_W'(1);
         end
         ST_EVICT: begin
            slot_in   = best_slot;
            evict_in  = best_owner;
            map_we    = 1'b1;
            map_waddr = best_owner;
            map_wdata = '0;
         end
         ST_WRITE: begin
            if (out_free) begin
               map_we       = 1'b1;
               slot_we      = 1'b1;
               rsp_valid_in = 1'b1;
               if (action_ff == ACT_FILL) begin
                  used_in = used_ff + USED_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         active_ff    <= CFG_RESET;
         scan_idx_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_idx_ff  <= scan_idx_in;
         if (csr_if.valid && csr_if.ready) begin
            active_ff <= csr_if.active_slots;
         end
      end
   end

   always_ff @(posedge clock) begin
      id_ff     <= id_in;
      stamp_ff  <= stamp_in;
      slot_ff   <= slot_in;
      action_ff <= action_in;
      evict_ff  <= evict_in;
      count_ff  <= count_in;
      if (state_ff == ST_WRITE && out_free) begin
         rsp_slot_ff   <= SLOT_OUT_W'(slot_ff);
         rsp_action_ff <= action_ff;
         rsp_evict_ff  <= EVICT_W'(evict_ff);
         rsp_count_ff  <= count_ff;
      end
   end

   // id map: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= map_wdata;
      end
      map_rd_ff <= map_mem[req_id];
   end

   // slot table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_ff] <= '{owner: id_ff, count: count_ff, stamp: stamp_ff};
      end
      slot_rd_ff <= slot_mem[slot_raddr];
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.slot       = rsp_slot_ff;
   assign rsp_if.action     = rsp_action_ff;
   assign rsp_if.evicted_id = rsp_evict_ff;
   assign rsp_if.new_count  = rsp_count_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_W'(MAX_SLOTS))
      else $error("slot fill count beyond table size");

   a_evict_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.action != ACT_REPLACE) |-> (rsp_if.evicted_id == '0))
      else $error("evicted id set on hit or fill");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.new_count != '0))
      else $error("zero use count in result");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (USED_W'(scan_idx_ff) < used_ff))
      else $error("victim scan beyond filled slots");

   a_fill_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE && out_free && action_ff == ACT_FILL)
         |=> (used_ff == USED_W'($past(used_ff) + USED_W'(1))))
      else $error("fill did not advance slot count");

endmodule
